>>> rtl/s3fp_pkg.sv
`default_nettype none
package s3fp_pkg;

	localparam int ENTRY_CAPACITY_DEF = 64;
	localparam int GHOST_MIN_DEF      = 64;
	localparam int FREQ_MAX_DEF       = 3;

	localparam int KEY_W  = 48;
	localparam int SIZE_W = 32;
	localparam int TIME_W = 32;
	localparam int CAP_W  = 48;

	localparam logic [CAP_W-1:0] SMALL_CAP_RESET = 48'd104857600;

	// request codes on req_type
	localparam logic [2:0] REQ_ADD    = 3'd0;
	localparam logic [2:0] REQ_TOUCH  = 3'd1;
	localparam logic [2:0] REQ_LOOKUP = 3'd2;
	localparam logic [2:0] REQ_DELETE = 3'd3;
	localparam logic [2:0] REQ_SCAN   = 3'd4;
	localparam logic [2:0] REQ_DECIDE = 3'd5;

	// decision codes
	localparam logic [1:0] DEC_EVICT = 2'd0;
	localparam logic [1:0] DEC_SKIP  = 2'd1;

	typedef enum logic [2:0] {
		OP_ADD, OP_TOUCH, OP_LOOKUP, OP_DELETE, OP_SCAN, OP_DECIDE, OP_NOP
	} op_t;

	typedef enum logic [2:0] {
		ST_OK, ST_NOT_FOUND, ST_FULL, ST_OFFER, ST_PASS_END, ST_NO_VICTIM
	} status_t;

	typedef struct packed {
		op_t               op;
		logic [KEY_W-1:0]  key;
		logic [SIZE_W-1:0] size;
		logic [TIME_W-1:0] ts;
		logic [1:0]        dec;
	} item_t;

	typedef struct packed {
		logic valid;
		logic pop;
	} item_hs_t;

	typedef enum logic [4:0] {
		BS_IDLE, BS_FRD, BS_FCHK, BS_FHIT, BS_FMISS, BS_GRD, BS_GCHK, BS_ADDG,
		BS_PUSH1, BS_PUSH2, BS_RMRD, BS_RMWR, BS_ERD, BS_ECHK, BS_SPICK, BS_SVIC,
		BS_DEC, BS_GINS, BS_TRIM, BS_TRIMK, BS_TRIMCLR, BS_EVICT, BS_RESP
	} bs_t;

endpackage
`default_nettype wire

>>> rtl/s3fp_ram.sv
`default_nettype none
module s3fp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> rtl/s3fp_front.sv
`default_nettype none
module s3fp_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [2:0]        req_type,
	input  wire logic [47:0]       key,
	input  wire logic [31:0]       size,
	input  wire logic [31:0]       time_stamp,
	input  wire logic [1:0]        decision,
	output s3fp_pkg::item_t        item,
	input  wire s3fp_pkg::item_hs_t hs_in,
	output logic                   item_valid
);

	s3fp_pkg::item_t mem_q [2];
	s3fp_pkg::item_t cls;
	logic            wr_q, rd_q;
	logic [1:0]      cnt_q;
	logic            push, pop;

	always_comb begin
		cls.key  = key;
		cls.size = size;
		cls.ts   = time_stamp;
		cls.dec  = decision;
		case (req_type)
			s3fp_pkg::REQ_ADD:    cls.op = s3fp_pkg::OP_ADD;
			s3fp_pkg::REQ_TOUCH:  cls.op = s3fp_pkg::OP_TOUCH;
			s3fp_pkg::REQ_LOOKUP: cls.op = s3fp_pkg::OP_LOOKUP;
			s3fp_pkg::REQ_DELETE: cls.op = s3fp_pkg::OP_DELETE;
			s3fp_pkg::REQ_SCAN:   cls.op = s3fp_pkg::OP_SCAN;
			s3fp_pkg::REQ_DECIDE: cls.op = s3fp_pkg::OP_DECIDE;
			default:              cls.op = s3fp_pkg::OP_NOP;
		endcase
	end

	assign in_ready   = (cnt_q != 2'd2);
	assign item_valid = (cnt_q != 2'd0);
	assign item       = mem_q[rd_q];
	assign push       = in_valid && in_ready;
	assign pop        = hs_in.pop && item_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= cls;
	end

endmodule
`default_nettype wire

>>> rtl/s3fp_back.sv
`default_nettype none
module s3fp_back #(
	parameter int ENTRY_CAPACITY = s3fp_pkg::ENTRY_CAPACITY_DEF,
	parameter int GHOST_MIN      = s3fp_pkg::GHOST_MIN_DEF,
	parameter int FREQ_MAX       = s3fp_pkg::FREQ_MAX_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire s3fp_pkg::item_t    item,
	input  wire logic               item_valid,
	output s3fp_pkg::item_hs_t      hs_out,
	input  wire logic [47:0]        small_capacity,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [2:0]              status,
	output logic [47:0]             out_key,
	output logic [31:0]             out_size,
	output logic [31:0]             out_atime,
	output logic [1:0]              out_freq,
	output logic                    ghost_hit,
	output logic                    from_small
);

	localparam int IW  = $clog2(ENTRY_CAPACITY);
	localparam int CW  = $clog2(ENTRY_CAPACITY + 1);
	localparam int LW  = $clog2(ENTRY_CAPACITY + 2);
	localparam int GS  = GHOST_MIN + ENTRY_CAPACITY;
	localparam int GW  = $clog2(GS);
	localparam int GCW = $clog2(GS + 1);
	localparam int FW  = $clog2(FREQ_MAX + 1);
	localparam logic [LW-1:0] SMALL_C = LW'(ENTRY_CAPACITY);
	localparam logic [LW-1:0] MAIN_C  = LW'(ENTRY_CAPACITY + 1);

	typedef struct packed {
		logic [47:0]   key;
		logic [31:0]   size;
		logic [31:0]   atime;
		logic [FW-1:0] freq;
		logic          in_small;
	} ent_t;

	localparam int EW = $bits(ent_t);

	s3fp_pkg::bs_t     state_q, state_d, ret_q, pret_q;
	s3fp_pkg::item_t   item_q;
	s3fp_pkg::status_t st_q;
	ent_t              ent_q, erd, e_wdata;
	logic [IW-1:0]     idx_q, free_q, pend_q;
	logic              free_ok_q, pend_ok_q, pass_q, rep_q, gh_q, ghit_q, pq_q;
	logic [CW-1:0]     scan_q, res_q, budget_q;
	logic [ENTRY_CAPACITY-1:0] valid_q;
	logic [LW-1:0]     shead_q, stail_q, mhead_q, mtail_q;
	logic [47:0]       sb_q;
	logic [GS-1:0]     glive_q;
	logic [GW-1:0]     ghead_q, gidx_q, gpos, ghead_inc;
	logic [GCW-1:0]    gcnt_q, gscan_q;
	logic [47:0]       gkey_q, grd;
	logic [GW:0]       gsum;

	logic              e_re, e_we, n_re, n_we, p_we, g_re, g_we;
	logic [IW-1:0]     e_raddr, e_waddr, n_waddr, p_waddr;
	logic [GW-1:0]     g_raddr;
	logic [LW-1:0]     n_wdata, p_wdata, nrd, prd;
	logic [EW-1:0]     e_rbits;

	logic [LW-1:0]     tail_sel, qcode, vsel;
	logic              pick_small, vsent, scan_end, gscan_end, key_hit, g_match;
	logic              trim_gt, cur_valid, cur_live;
	logic [FW-1:0]     freq_inc;
	logic [31:0]       lim;
	logic [47:0]       sb_minus;

	s3fp_ram #(.WIDTH(EW), .DEPTH(ENTRY_CAPACITY)) u_ent (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.re(e_re), .raddr(e_raddr), .rdata(e_rbits)
	);
	s3fp_ram #(.WIDTH(LW), .DEPTH(ENTRY_CAPACITY)) u_next (
		.clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
		.re(n_re), .raddr(idx_q), .rdata(nrd)
	);
	s3fp_ram #(.WIDTH(LW), .DEPTH(ENTRY_CAPACITY)) u_prev (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.re(n_re), .raddr(idx_q), .rdata(prd)
	);
	s3fp_ram #(.WIDTH(48), .DEPTH(GS)) u_ring (
		.clk(clk), .we(g_we), .waddr(gpos), .wdata(gkey_q),
		.re(g_re), .raddr(g_raddr), .rdata(grd)
	);

	assign erd        = ent_t'(e_rbits);
	assign tail_sel   = pq_q ? mtail_q : stail_q;
	assign qcode      = pq_q ? MAIN_C : SMALL_C;
	assign pick_small = ((sb_q >= small_capacity) || (mhead_q == MAIN_C)) && (shead_q != SMALL_C);
	assign vsel       = pick_small ? shead_q : mhead_q;
	assign vsent      = (vsel == SMALL_C) || (vsel == MAIN_C);
	assign scan_end   = (scan_q == CW'(ENTRY_CAPACITY));
	assign gscan_end  = (gscan_q == GCW'(GS));
	assign cur_valid  = valid_q[scan_q[IW-1:0]];
	assign cur_live   = glive_q[gscan_q[GW-1:0]];
	assign key_hit    = (erd.key == item_q.key);
	assign g_match    = (grd == gkey_q);
	assign freq_inc   = (ent_q.freq < FW'(FREQ_MAX)) ? ent_q.freq + FW'(1) : ent_q.freq;
	assign sb_minus   = sb_q - 48'(ent_q.size);
	assign gsum       = (GW+1)'(ghead_q) + (GW+1)'(gcnt_q);
	assign gpos       = (gsum >= (GW+1)'(GS)) ? GW'(gsum - (GW+1)'(GS)) : GW'(gsum);
	assign ghead_inc  = (ghead_q == GW'(GS - 1)) ? '0 : ghead_q + GW'(1);
	assign lim        = (32'(res_q) > 32'(GHOST_MIN)) ? 32'(res_q) : 32'(GHOST_MIN);
	assign trim_gt    = 32'(gcnt_q) > lim;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			s3fp_pkg::BS_IDLE:
				if (item_valid) begin
					case (item.op)
						s3fp_pkg::OP_ADD, s3fp_pkg::OP_TOUCH,
						s3fp_pkg::OP_LOOKUP, s3fp_pkg::OP_DELETE:
							state_d = s3fp_pkg::BS_FRD;
						s3fp_pkg::OP_SCAN:
							state_d = (pass_q && pend_ok_q) ? s3fp_pkg::BS_ERD : s3fp_pkg::BS_SPICK;
						s3fp_pkg::OP_DECIDE:
							state_d = (pass_q && pend_ok_q) ? s3fp_pkg::BS_ERD : s3fp_pkg::BS_RESP;
						default:
							state_d = s3fp_pkg::BS_RESP;
					endcase
				end
			s3fp_pkg::BS_FRD:
				if (scan_end)
					state_d = s3fp_pkg::BS_FMISS;
				else if (cur_valid)
					state_d = s3fp_pkg::BS_FCHK;
			s3fp_pkg::BS_FCHK:
				state_d = key_hit ? s3fp_pkg::BS_FHIT : s3fp_pkg::BS_FRD;
			s3fp_pkg::BS_FHIT:
				state_d = (item_q.op == s3fp_pkg::OP_DELETE) ? s3fp_pkg::BS_RMRD : s3fp_pkg::BS_RESP;
			s3fp_pkg::BS_FMISS:
				state_d = (item_q.op == s3fp_pkg::OP_ADD && res_q < CW'(ENTRY_CAPACITY) && free_ok_q)
					? s3fp_pkg::BS_GRD : s3fp_pkg::BS_RESP;
			s3fp_pkg::BS_GRD:
				if (gscan_end)
					state_d = ret_q;
				else if (cur_live)
					state_d = s3fp_pkg::BS_GCHK;
			s3fp_pkg::BS_GCHK:
				state_d = g_match ? ret_q : s3fp_pkg::BS_GRD;
			s3fp_pkg::BS_ADDG:
				state_d = s3fp_pkg::BS_PUSH1;
			s3fp_pkg::BS_PUSH1:
				state_d = (tail_sel == qcode) ? pret_q : s3fp_pkg::BS_PUSH2;
			s3fp_pkg::BS_PUSH2:
				state_d = pret_q;
			s3fp_pkg::BS_RMRD:
				state_d = s3fp_pkg::BS_RMWR;
			s3fp_pkg::BS_RMWR:
				state_d = ret_q;
			s3fp_pkg::BS_ERD:
				state_d = s3fp_pkg::BS_ECHK;
			s3fp_pkg::BS_ECHK:
				state_d = ret_q;
			s3fp_pkg::BS_SPICK:
				state_d = (budget_q != '0 && res_q != '0 && !vsent)
					? s3fp_pkg::BS_ERD : s3fp_pkg::BS_RESP;
			s3fp_pkg::BS_SVIC:
				state_d = (ent_q.freq != '0) ? s3fp_pkg::BS_RMRD : s3fp_pkg::BS_RESP;
			s3fp_pkg::BS_DEC:
				case (item_q.dec)
					s3fp_pkg::DEC_EVICT:
						state_d = ent_q.in_small ? s3fp_pkg::BS_GRD : s3fp_pkg::BS_EVICT;
					s3fp_pkg::DEC_SKIP:
						state_d = s3fp_pkg::BS_RMRD;
					default:
						state_d = s3fp_pkg::BS_RESP;
				endcase
			s3fp_pkg::BS_GINS:
				state_d = ghit_q ? s3fp_pkg::BS_EVICT : s3fp_pkg::BS_TRIM;
			s3fp_pkg::BS_TRIM:
				state_d = trim_gt ? s3fp_pkg::BS_TRIMK : s3fp_pkg::BS_EVICT;
			s3fp_pkg::BS_TRIMK:
				state_d = s3fp_pkg::BS_GRD;
			s3fp_pkg::BS_TRIMCLR:
				state_d = s3fp_pkg::BS_TRIM;
			s3fp_pkg::BS_EVICT:
				state_d = s3fp_pkg::BS_RMRD;
			s3fp_pkg::BS_RESP:
				if (!out_valid || out_ready)
					state_d = s3fp_pkg::BS_IDLE;
			default:
				state_d = s3fp_pkg::BS_IDLE;
		endcase
	end

	// memory ports and queue pop
	always_comb begin
		hs_out.valid = 1'b0;
		hs_out.pop   = (state_q == s3fp_pkg::BS_IDLE);
		e_re    = 1'b0;
		e_raddr = idx_q;
		e_we    = 1'b0;
		e_waddr = idx_q;
		e_wdata = ent_q;
		n_re    = 1'b0;
		n_we    = 1'b0;
		n_waddr = idx_q;
		n_wdata = qcode;
		p_we    = 1'b0;
		p_waddr = idx_q;
		p_wdata = tail_sel;
		g_re    = 1'b0;
		g_raddr = gscan_q[GW-1:0];
		g_we    = 1'b0;
		case (state_q)
			s3fp_pkg::BS_FRD: begin
				e_re    = !scan_end && cur_valid;
				e_raddr = scan_q[IW-1:0];
			end
			s3fp_pkg::BS_ERD:
				e_re = 1'b1;
			s3fp_pkg::BS_FHIT:
				if (item_q.op == s3fp_pkg::OP_ADD) begin
					e_we           = 1'b1;
					e_wdata.size   = item_q.size;
					e_wdata.atime  = item_q.ts;
					e_wdata.freq   = '0;
				end else if (item_q.op == s3fp_pkg::OP_TOUCH) begin
					e_we          = 1'b1;
					e_wdata.atime = item_q.ts;
					e_wdata.freq  = freq_inc;
				end
			s3fp_pkg::BS_ADDG: begin
				e_we             = 1'b1;
				e_wdata.key      = item_q.key;
				e_wdata.size     = item_q.size;
				e_wdata.atime    = item_q.ts;
				e_wdata.freq     = '0;
				e_wdata.in_small = !ghit_q;
			end
			s3fp_pkg::BS_SVIC:
				if (ent_q.freq != '0) begin
					e_we             = 1'b1;
					e_wdata.freq     = '0;
					e_wdata.in_small = 1'b0;
				end
			s3fp_pkg::BS_DEC:
				if (item_q.dec == s3fp_pkg::DEC_SKIP) begin
					e_we             = 1'b1;
					e_wdata.in_small = 1'b0;
				end
			s3fp_pkg::BS_PUSH1: begin
				n_we = 1'b1;
				p_we = 1'b1;
			end
			s3fp_pkg::BS_PUSH2: begin
				n_we    = 1'b1;
				n_waddr = tail_sel[IW-1:0];
				n_wdata = LW'(idx_q);
			end
			s3fp_pkg::BS_RMRD:
				n_re = 1'b1;
			s3fp_pkg::BS_RMWR: begin
				// unlink: neighbors point past the node, sentinels live in head/tail regs
				n_we    = (prd != SMALL_C) && (prd != MAIN_C);
				n_waddr = prd[IW-1:0];
				n_wdata = nrd;
				p_we    = (nrd != SMALL_C) && (nrd != MAIN_C);
				p_waddr = nrd[IW-1:0];
				p_wdata = prd;
			end
			s3fp_pkg::BS_GRD:
				g_re = !gscan_end && cur_live;
			s3fp_pkg::BS_GINS:
				g_we = !ghit_q;
			s3fp_pkg::BS_TRIM: begin
				g_re    = trim_gt;
				g_raddr = ghead_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= s3fp_pkg::BS_IDLE;
			ret_q      <= s3fp_pkg::BS_RESP;
			pret_q     <= s3fp_pkg::BS_RESP;
			item_q     <= '0;
			st_q       <= s3fp_pkg::ST_OK;
			ent_q      <= '0;
			idx_q      <= '0;
			free_q     <= '0;
			pend_q     <= '0;
			free_ok_q  <= 1'b0;
			pend_ok_q  <= 1'b0;
			pass_q     <= 1'b0;
			rep_q      <= 1'b0;
			gh_q       <= 1'b0;
			ghit_q     <= 1'b0;
			pq_q       <= 1'b0;
			scan_q     <= '0;
			res_q      <= '0;
			budget_q   <= '0;
			valid_q    <= '0;
			shead_q    <= SMALL_C;
			stail_q    <= SMALL_C;
			mhead_q    <= MAIN_C;
			mtail_q    <= MAIN_C;
			sb_q       <= '0;
			glive_q    <= '0;
			ghead_q    <= '0;
			gidx_q     <= '0;
			gcnt_q     <= '0;
			gscan_q    <= '0;
			gkey_q     <= '0;
			out_valid  <= 1'b0;
			status     <= '0;
			out_key    <= '0;
			out_size   <= '0;
			out_atime  <= '0;
			out_freq   <= '0;
			ghost_hit  <= 1'b0;
			from_small <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			case (state_q)
				s3fp_pkg::BS_IDLE:
					if (item_valid) begin
						item_q    <= item;
						scan_q    <= '0;
						free_ok_q <= 1'b0;
						gh_q      <= 1'b0;
						rep_q     <= 1'b0;
						st_q      <= s3fp_pkg::ST_OK;
						case (item.op)
							s3fp_pkg::OP_SCAN:
								if (pass_q && pend_ok_q) begin
									// offer the pending victim again
									idx_q <= pend_q;
									st_q  <= s3fp_pkg::ST_OFFER;
									rep_q <= 1'b1;
									ret_q <= s3fp_pkg::BS_RESP;
								end else if (!pass_q) begin
									pass_q   <= 1'b1;
									budget_q <= res_q;
								end
							s3fp_pkg::OP_DECIDE:
								if (pass_q && pend_ok_q) begin
									idx_q <= pend_q;
									ret_q <= s3fp_pkg::BS_DEC;
								end else begin
									st_q <= s3fp_pkg::ST_NO_VICTIM;
								end
							default: ;
						endcase
					end
				s3fp_pkg::BS_FRD:
					if (!scan_end && !cur_valid) begin
						if (!free_ok_q) begin
							free_q    <= scan_q[IW-1:0];
							free_ok_q <= 1'b1;
						end
						scan_q <= scan_q + CW'(1);
					end
				s3fp_pkg::BS_FCHK:
					if (key_hit) begin
						idx_q <= scan_q[IW-1:0];
						ent_q <= erd;
					end else begin
						scan_q <= scan_q + CW'(1);
					end
				s3fp_pkg::BS_FHIT: begin
					rep_q <= 1'b1;
					case (item_q.op)
						s3fp_pkg::OP_ADD: begin
							if (ent_q.in_small)
								sb_q <= sb_minus + 48'(item_q.size);
							ent_q <= e_wdata;
						end
						s3fp_pkg::OP_TOUCH:
							ent_q <= e_wdata;
						s3fp_pkg::OP_DELETE: begin
							if (ent_q.in_small)
								sb_q <= sb_minus;
							valid_q[idx_q] <= 1'b0;
							res_q          <= res_q - CW'(1);
							if (pend_ok_q && pend_q == idx_q)
								pend_ok_q <= 1'b0;
							ret_q <= s3fp_pkg::BS_RESP;
						end
						default: ;
					endcase
				end
				s3fp_pkg::BS_FMISS:
					if (item_q.op == s3fp_pkg::OP_ADD) begin
						if (res_q >= CW'(ENTRY_CAPACITY) || !free_ok_q) begin
							st_q <= s3fp_pkg::ST_FULL;
						end else begin
							idx_q   <= free_q;
							gkey_q  <= item_q.key;
							gscan_q <= '0;
							ret_q   <= s3fp_pkg::BS_ADDG;
						end
					end else begin
						st_q <= s3fp_pkg::ST_NOT_FOUND;
					end
				s3fp_pkg::BS_GRD:
					if (gscan_end)
						ghit_q <= 1'b0;
					else if (!cur_live)
						gscan_q <= gscan_q + GCW'(1);
				s3fp_pkg::BS_GCHK:
					if (g_match) begin
						ghit_q <= 1'b1;
						gidx_q <= gscan_q[GW-1:0];
					end else begin
						gscan_q <= gscan_q + GCW'(1);
					end
				s3fp_pkg::BS_ADDG: begin
					ent_q          <= e_wdata;
					valid_q[idx_q] <= 1'b1;
					res_q          <= res_q + CW'(1);
					rep_q          <= 1'b1;
					pret_q         <= s3fp_pkg::BS_RESP;
					if (ghit_q) begin
						glive_q[gidx_q] <= 1'b0;
						gh_q            <= 1'b1;
						pq_q            <= 1'b1;
					end else begin
						sb_q <= sb_q + 48'(item_q.size);
						pq_q <= 1'b0;
					end
				end
				s3fp_pkg::BS_PUSH1:
					if (tail_sel == qcode) begin
						if (pq_q) begin
							mhead_q <= LW'(idx_q);
							mtail_q <= LW'(idx_q);
						end else begin
							shead_q <= LW'(idx_q);
							stail_q <= LW'(idx_q);
						end
					end
				s3fp_pkg::BS_PUSH2:
					if (pq_q)
						mtail_q <= LW'(idx_q);
					else
						stail_q <= LW'(idx_q);
				s3fp_pkg::BS_RMWR: begin
					if (nrd == SMALL_C)
						stail_q <= prd;
					else if (nrd == MAIN_C)
						mtail_q <= prd;
					if (prd == SMALL_C)
						shead_q <= nrd;
					else if (prd == MAIN_C)
						mhead_q <= nrd;
				end
				s3fp_pkg::BS_ECHK:
					ent_q <= erd;
				s3fp_pkg::BS_SPICK:
					if (budget_q != '0 && res_q != '0) begin
						budget_q <= budget_q - CW'(1);
						if (!vsent) begin
							idx_q <= vsel[IW-1:0];
							ret_q <= s3fp_pkg::BS_SVIC;
						end else begin
							pass_q    <= 1'b0;
							budget_q  <= '0;
							pend_ok_q <= 1'b0;
							st_q      <= s3fp_pkg::ST_PASS_END;
						end
					end else begin
						pass_q    <= 1'b0;
						budget_q  <= '0;
						pend_ok_q <= 1'b0;
						st_q      <= s3fp_pkg::ST_PASS_END;
					end
				s3fp_pkg::BS_SVIC:
					if (ent_q.freq != '0) begin
						// second chance: clear the count and requeue at the tail of main
						if (ent_q.in_small)
							sb_q <= sb_minus;
						pq_q   <= 1'b1;
						pret_q <= s3fp_pkg::BS_SPICK;
						ret_q  <= s3fp_pkg::BS_PUSH1;
					end else begin
						pend_q    <= idx_q;
						pend_ok_q <= 1'b1;
						st_q      <= s3fp_pkg::ST_OFFER;
						rep_q     <= 1'b1;
					end
				s3fp_pkg::BS_DEC:
					case (item_q.dec)
						s3fp_pkg::DEC_EVICT: begin
							rep_q   <= 1'b1;
							gkey_q  <= ent_q.key;
							gscan_q <= '0;
							ret_q   <= s3fp_pkg::BS_GINS;
						end
						s3fp_pkg::DEC_SKIP: begin
							rep_q <= 1'b1;
							if (ent_q.in_small)
								sb_q <= sb_minus;
							pend_ok_q <= 1'b0;
							pq_q      <= 1'b1;
							pret_q    <= s3fp_pkg::BS_RESP;
							ret_q     <= s3fp_pkg::BS_PUSH1;
						end
						default: begin
							pass_q    <= 1'b0;
							budget_q  <= '0;
							pend_ok_q <= 1'b0;
							st_q      <= s3fp_pkg::ST_PASS_END;
						end
					endcase
				s3fp_pkg::BS_GINS:
					if (!ghit_q) begin
						glive_q[gpos] <= 1'b1;
						gcnt_q        <= gcnt_q + GCW'(1);
					end
				s3fp_pkg::BS_TRIMK: begin
					gkey_q  <= grd;
					gscan_q <= '0;
					ret_q   <= s3fp_pkg::BS_TRIMCLR;
				end
				s3fp_pkg::BS_TRIMCLR: begin
					// drop the oldest ring key from the ghost set
					if (ghit_q)
						glive_q[gidx_q] <= 1'b0;
					ghead_q <= ghead_inc;
					gcnt_q  <= gcnt_q - GCW'(1);
				end
				s3fp_pkg::BS_EVICT: begin
					if (ent_q.in_small)
						sb_q <= sb_minus;
					valid_q[idx_q] <= 1'b0;
					res_q          <= res_q - CW'(1);
					pend_ok_q      <= 1'b0;
					ret_q          <= s3fp_pkg::BS_RESP;
				end
				s3fp_pkg::BS_RESP:
					if (!out_valid || out_ready) begin
						out_valid  <= 1'b1;
						status     <= st_q;
						out_key    <= rep_q ? ent_q.key : '0;
						out_size   <= rep_q ? ent_q.size : '0;
						out_atime  <= rep_q ? ent_q.atime : '0;
						out_freq   <= rep_q ? 2'(ent_q.freq) : '0;
						ghost_hit  <= gh_q;
						from_small <= rep_q && ent_q.in_small;
					end
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/s3fifo_replacement_policy_unit.sv
`default_nettype none
// S3-FIFO replacement unit: a front stage decodes requests into a two-word
// queue, and a sequencer in the back executes them one at a time against an
// entry table, two linked FIFO queues (small, main) and a ghost ring, all held
// in single-port-per-direction RAMs with registered reads. Per request:
// a key search reads each resident table entry and skips empty slots; an
// add that misses then walks the ghost ring (GHOST_MIN+ENTRY_CAPACITY
// slots); touch and lookup respond once the search ends; a scan of a
// pending victim rereads only that entry; a victim moved to main in a scan
// is relinked at the main tail; evicting a small entry walks the ghost ring
// for its key and again per aged-out key. No clearing pass is needed after
// reset. small_capacity is written through cfg_we/cfg_data.
module s3fifo_replacement_policy_unit #(
	parameter int ENTRY_CAPACITY = s3fp_pkg::ENTRY_CAPACITY_DEF,
	parameter int GHOST_MIN      = s3fp_pkg::GHOST_MIN_DEF,
	parameter int FREQ_MAX       = s3fp_pkg::FREQ_MAX_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [47:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  req_type,
	input  wire logic [47:0] key,
	input  wire logic [31:0] size,
	input  wire logic [31:0] time_stamp,
	input  wire logic [1:0]  decision,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [47:0]      out_key,
	output logic [31:0]      out_size,
	output logic [31:0]      out_atime,
	output logic [1:0]       out_freq,
	output logic             ghost_hit,
	output logic             from_small
);

	logic [47:0]        small_cap_q;
	s3fp_pkg::item_t    item;
	s3fp_pkg::item_hs_t hs;
	logic               item_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			small_cap_q <= s3fp_pkg::SMALL_CAP_RESET;
		else if (cfg_we)
			small_cap_q <= cfg_data;
	end

	s3fp_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .key(key), .size(size),
		.time_stamp(time_stamp), .decision(decision),
		.item(item), .hs_in(hs), .item_valid(item_valid)
	);

	s3fp_back #(
		.ENTRY_CAPACITY(ENTRY_CAPACITY), .GHOST_MIN(GHOST_MIN), .FREQ_MAX(FREQ_MAX)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.item(item), .item_valid(item_valid), .hs_out(hs),
		.small_capacity(small_cap_q),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .out_key(out_key), .out_size(out_size),
		.out_atime(out_atime), .out_freq(out_freq),
		.ghost_hit(ghost_hit), .from_small(from_small)
	);

	a_ghost_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ghost_hit |-> status == s3fp_pkg::ST_OK)
		else $error("ghost hit reported on a failed request");

	a_ghost_in_main: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ghost_hit |-> !from_small && out_freq == 2'd0)
		else $error("ghost hit entry not placed fresh in main");

	a_no_report: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == s3fp_pkg::ST_NOT_FOUND || status == s3fp_pkg::ST_FULL ||
		status == s3fp_pkg::ST_PASS_END || status == s3fp_pkg::ST_NO_VICTIM)
		|-> out_key == 48'd0 && out_size == 32'd0 && !from_small)
		else $error("entry fields on a result without an entry");

endmodule
`default_nettype wire
